// ===== sv/pfre_pkg.sv =====
// ----------------------------------------------------------------------------
// pfre_pkg
// Shared types and constants for the page frame replacement engine.
// ----------------------------------------------------------------------------
package pfre_pkg;

  localparam int MAX_FRAME_COUNT_DEF = 1024;
  localparam int ADDRESS_BITS_DEF    = 32;

  localparam int PAGE_W   = 22;
  localparam int STAMP_W  = 32;
  localparam int TOTAL_W  = 32;
  localparam int FIDX_W   = 10;
  localparam int PHASE_W  = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [4:0] MIN_PAGE_SHIFT = 5'd10;

  // replacement policies
  localparam logic [1:0] POL_NRU   = 2'd0;
  localparam logic [1:0] POL_LRU   = 2'd1;
  localparam logic [1:0] POL_FIFO  = 2'd2;
  localparam logic [1:0] POL_CLOCK = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLICY      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_SHIFT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NRU_PERIOD  = 2'd3;

  typedef struct packed {
    logic [PAGE_W-1:0]  page;
    logic               valid;
    logic               referenced;
    logic               modified;
    logic [STAMP_W-1:0] last_use;
    logic [STAMP_W-1:0] load_time;
  } entry_t;

endpackage

// ===== sv/page_frame_replacement_engine.sv =====
// ----------------------------------------------------------------------------
// page_frame_replacement_engine
// Frame lookup and victim choice (NRU, LRU, FIFO second chance, clock)
// over a frame table held in one synchronous memory.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  request   start / busy         address, is_write
//  result    done (1-cycle)       hit, frame_index, evicted_valid,
//                                 evicted_page, writeback, fault_count,
//                                 writeback_count
//  config    cfg_write            cfg_index, cfg_data
//
//  A request is served by one scan of the n frames in use through the memory
//  read port, then a read-modify-write of the chosen frame. The next request is
//  taken in the done cycle at the earliest. FIFO adds a rescan per reprieved
//  frame; clock adds a read and a check of each frame the hand steps over.
//  After reset a clearing pass over all MAX_FRAME_COUNT entries holds busy high.
//  Results cannot be stalled; done is high for one cycle per request.
// ----------------------------------------------------------------------------
module page_frame_replacement_engine import pfre_pkg::*; #(
  parameter int MAX_FRAME_COUNT = MAX_FRAME_COUNT_DEF,
  parameter int ADDRESS_BITS    = ADDRESS_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [ADDRESS_BITS-1:0] address,
  input  logic                    is_write,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  output logic                    done,
  output logic                    hit,
  output logic [FIDX_W-1:0]       frame_index,
  output logic                    evicted_valid,
  output logic [PAGE_W-1:0]       evicted_page,
  output logic                    writeback,
  output logic [TOTAL_W-1:0]      fault_count,
  output logic [TOTAL_W-1:0]      writeback_count
);

  localparam int FW = $clog2(MAX_FRAME_COUNT);
  localparam int CW = FW + 1;

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_SCAN   = 10'b0000000100,
    S_DECIDE = 10'b0000001000,
    S_FREAD  = 10'b0000010000,
    S_FWRITE = 10'b0000100000,
    S_CREAD  = 10'b0001000000,
    S_CCHECK = 10'b0010000000,
    S_VREAD  = 10'b0100000000,
    S_UPDATE = 10'b1000000000
  } state_t;

  state_t state;

  // configuration
  logic [1:0]            policy;
  logic [4:0]            page_shift;
  logic [CFG_DATA_W-1:0] frames_in_use;
  logic [PHASE_W-1:0]    nru_clear_period;

  // global state
  logic [FW-1:0]      clock_hand;
  logic [STAMP_W-1:0] access_tick;
  logic [PHASE_W-1:0] nru_phase;
  logic [TOTAL_W-1:0] fault_total;
  logic [TOTAL_W-1:0] writeback_total;

  // per-request
  logic [PAGE_W-1:0] req_page;
  logic              req_write;
  logic [CW-1:0]     n;
  logic              clr;
  logic              pass_main;
  logic [CW-1:0]     cnt;
  logic              pend;
  logic [FW-1:0]     pidx;
  logic              hit_f;
  logic [FW-1:0]     hit_i;
  logic              free_f;
  logic [FW-1:0]     free_i;
  logic [3:0]        cls_f;
  logic [FW-1:0]     cls_i [4];
  logic [STAMP_W-1:0] lru_min;
  logic [FW-1:0]     lru_i;
  logic [STAMP_W-1:0] fifo_min;
  logic [FW-1:0]     fifo_i;
  logic              fifo_ref;
  logic [FW-1:0]     vic;

  // memory ports
  logic          mem_we;
  logic [FW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [FW-1:0] mem_raddr;
  entry_t        rd;

  pfre_mem #(
    .DEPTH (MAX_FRAME_COUNT),
    .AW    (FW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd)
  );

  // request decode
  logic [4:0]               eff_shift;
  logic [ADDRESS_BITS+PAGE_W-1:0] addr_ext;
  logic [PAGE_W-1:0]        new_page;
  logic [31:0]              n32;
  logic [STAMP_W-1:0]       tick_next;

  assign eff_shift = (page_shift < MIN_PAGE_SHIFT) ? MIN_PAGE_SHIFT : page_shift;
  assign addr_ext  = {{PAGE_W{1'b0}}, address} >> eff_shift;
  assign new_page  = addr_ext[PAGE_W-1:0];
  assign n32 = (frames_in_use == '0) ? 32'd1 :
               ((32'(frames_in_use) > 32'(MAX_FRAME_COUNT)) ? 32'(MAX_FRAME_COUNT)
                                                            : 32'(frames_in_use));
  assign tick_next = access_tick + 1'b1;

  assign busy = (state != S_IDLE);

  // hand handling
  logic [CW-1:0] hand_inc;
  assign hand_inc = {1'b0, clock_hand} + 1'b1;

  // victim entry outcome
  logic               ev_v;
  logic               wb_v;
  logic [TOTAL_W-1:0] fault_upd;
  logic [TOTAL_W-1:0] wb_upd;
  assign ev_v = !hit_f && rd.valid;
  assign wb_v = ev_v && rd.modified;
  assign fault_upd = (hit_f || fault_total == '1) ? fault_total : fault_total + 1'b1;
  assign wb_upd    = (!wb_v || writeback_total == '1) ? writeback_total
                                                      : writeback_total + 1'b1;

  // memory port muxing
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pidx;
    mem_wdata = rd;
    mem_raddr = cnt[FW-1:0];
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt[FW-1:0];
        mem_wdata = '0;
      end
      S_SCAN: begin
        mem_we    = pend && clr;
        mem_waddr = pidx;
        mem_wdata.referenced = 1'b0;
      end
      S_FREAD: begin
        mem_raddr = fifo_i;
      end
      S_FWRITE: begin
        mem_we    = 1'b1;
        mem_waddr = fifo_i;
        mem_wdata.referenced = 1'b0;
        mem_wdata.load_time  = access_tick;
        mem_wdata.last_use   = access_tick;
      end
      S_CREAD: begin
        mem_raddr = clock_hand;
      end
      S_CCHECK: begin
        mem_we    = rd.referenced;
        mem_waddr = clock_hand;
        mem_wdata.referenced = 1'b0;
      end
      S_VREAD: begin
        mem_raddr = vic;
      end
      S_UPDATE: begin
        mem_we    = 1'b1;
        mem_waddr = vic;
        if (hit_f) begin
          mem_wdata.referenced = 1'b1;
          mem_wdata.modified   = rd.modified | req_write;
          mem_wdata.last_use   = access_tick;
        end else begin
          mem_wdata.page       = req_page;
          mem_wdata.valid      = 1'b1;
          mem_wdata.referenced = 1'b1;
          mem_wdata.modified   = req_write;
          mem_wdata.last_use   = access_tick;
          mem_wdata.load_time  = access_tick;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  logic [1:0] cls_cur;
  assign cls_cur = {(clr ? 1'b0 : rd.referenced), rd.modified};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state            <= S_CLEAR;
      cnt              <= '0;
      pend             <= 1'b0;
      policy           <= POL_NRU;
      page_shift       <= 5'd12;
      frames_in_use    <= 11'd1024;
      nru_clear_period <= 4'd4;
      clock_hand       <= '0;
      access_tick      <= '0;
      nru_phase        <= '0;
      fault_total      <= '0;
      writeback_total  <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_POLICY:     policy           <= cfg_data[1:0];
          REG_PAGE_SHIFT: page_shift       <= cfg_data[4:0];
          REG_FRAMES:     frames_in_use    <= cfg_data;
          REG_NRU_PERIOD: nru_clear_period <= cfg_data[PHASE_W-1:0];
          default: ;
        endcase
      end

      case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == CW'(MAX_FRAME_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (start) begin
            req_page    <= new_page;
            req_write   <= is_write;
            n           <= n32[CW-1:0];
            access_tick <= tick_next;
            clr         <= 1'b0;
            if (policy == POL_NRU) begin
              if (nru_phase == nru_clear_period) begin
                clr       <= 1'b1;
                nru_phase <= '0;
              end else begin
                nru_phase <= nru_phase + 1'b1;
              end
            end
            pass_main <= 1'b1;
            cnt       <= '0;
            pend      <= 1'b0;
            hit_f     <= 1'b0;
            hit_i     <= '0;
            free_f    <= 1'b0;
            free_i    <= '0;
            cls_f     <= '0;
            lru_min   <= tick_next;
            lru_i     <= '0;
            fifo_min  <= tick_next;
            fifo_i    <= '0;
            fifo_ref  <= 1'b0;
            state     <= S_SCAN;
          end
        end

        S_SCAN: begin
          if (cnt < n) begin
            cnt <= cnt + 1'b1;
          end
          pend <= (cnt < n);
          pidx <= cnt[FW-1:0];
          if (pend) begin
            if (pass_main) begin
              if (rd.valid && rd.page == req_page && !hit_f) begin
                hit_f <= 1'b1;
                hit_i <= pidx;
              end
              if (!rd.valid && !free_f) begin
                free_f <= 1'b1;
                free_i <= pidx;
              end
              if (!cls_f[cls_cur]) begin
                cls_f[cls_cur] <= 1'b1;
                cls_i[cls_cur] <= pidx;
              end
              if (rd.last_use < lru_min) begin
                lru_min <= rd.last_use;
                lru_i   <= pidx;
              end
            end
            if (rd.load_time < fifo_min) begin
              fifo_min <= rd.load_time;
              fifo_i   <= pidx;
            end
            // frame 0 is the fallback pick when nothing is older
            if (rd.load_time < fifo_min || pidx == '0) begin
              fifo_ref <= rd.referenced;
            end
          end
          if (!pend && cnt >= n) begin
            state <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          state <= S_VREAD;
          if (hit_f) begin
            vic <= hit_i;
          end else begin
            case (policy)
              POL_NRU: begin
                if (free_f)        vic <= free_i;
                else if (cls_f[0]) vic <= cls_i[0];
                else if (cls_f[1]) vic <= cls_i[1];
                else if (cls_f[2]) vic <= cls_i[2];
                else if (cls_f[3]) vic <= cls_i[3];
                else               vic <= '0;
              end
              POL_LRU: begin
                vic <= lru_i;
              end
              POL_FIFO: begin
                vic <= fifo_i;
                if (fifo_ref) begin
                  state <= S_FREAD;
                end
              end
              default: begin
                if ({1'b0, clock_hand} >= n) begin
                  clock_hand <= '0;
                end
                state <= S_CREAD;
              end
            endcase
          end
        end

        S_FREAD: begin
          state <= S_FWRITE;
        end

        S_FWRITE: begin
          // reprieve written back; rescan for the oldest load time
          pass_main <= 1'b0;
          cnt       <= '0;
          pend      <= 1'b0;
          fifo_min  <= access_tick;
          fifo_i    <= '0;
          fifo_ref  <= 1'b0;
          state     <= S_SCAN;
        end

        S_CREAD: begin
          state <= S_CCHECK;
        end

        S_CCHECK: begin
          clock_hand <= (hand_inc == n) ? '0 : hand_inc[FW-1:0];
          if (!rd.referenced) begin
            vic   <= clock_hand;
            state <= S_VREAD;
          end else begin
            state <= S_CREAD;
          end
        end

        S_VREAD: begin
          state <= S_UPDATE;
        end

        S_UPDATE: begin
          fault_total     <= fault_upd;
          writeback_total <= wb_upd;
          hit             <= hit_f;
          frame_index     <= FIDX_W'(vic);
          evicted_valid   <= ev_v;
          evicted_page    <= ev_v ? rd.page : '0;
          writeback       <= wb_v;
          fault_count     <= fault_upd;
          writeback_count <= wb_upd;
          done            <= 1'b1;
          state           <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_after_update: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_UPDATE))
    else $error("done without update");

  a_wb_needs_evict: assert property (@(posedge clk) disable iff (rst)
    done && writeback |-> evicted_valid && !hit)
    else $error("writeback without eviction");

  a_miss_counts: assert property (@(posedge clk) disable iff (rst)
    done && !hit |-> fault_count != '0)
    else $error("miss not counted");

  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> busy && !mem_we || mem_wdata == '0)
    else $error("clearing pass writes nonzero");
`endif

endmodule

// ===== sv/pfre_mem.sv =====
// ----------------------------------------------------------------------------
// pfre_mem
// Frame table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pfre_mem import pfre_pkg::*; #(
  parameter int DEPTH = MAX_FRAME_COUNT_DEF,
  parameter int AW    = $clog2(MAX_FRAME_COUNT_DEF)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
